>>> rtl/asymmetric_one_pole_smoother_unit_defines.svh
// assertion macros shared by the smoother rtl
`ifndef ASYMMETRIC_ONE_POLE_SMOOTHER_UNIT_DEFINES_SVH
`define ASYMMETRIC_ONE_POLE_SMOOTHER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define APS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define APS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/aps_pkg.sv
`timescale 1ns / 1ps

package aps_pkg;

  localparam int CHANNELS  = 64;
  localparam int CH_W      = 6;
  localparam int CNT_W     = 7;
  localparam int DATA_W    = 32;
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [COEF_W-1:0] COEF_ONE      = 16'd32768;
  localparam logic [COEF_W-1:0] COEF_UP_RST   = 16'd16384;
  localparam logic [COEF_W-1:0] COEF_DOWN_RST = 16'd29491;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_UP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_DOWN = 2'd1;

  typedef enum logic [1:0] {
    OP_SINGLE = 2'd0,
    OP_LIST   = 2'd1,
    OP_REPLAY = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_t;

  // weights above one clamp to one
  function automatic logic [COEF_W-1:0] sat_coef(input logic [COEF_W-1:0] c);
    sat_coef = (c > COEF_ONE) ? COEF_ONE : c;
  endfunction

endpackage

>>> rtl/asymmetric_one_pole_smoother_unit.sv
`timescale 1ns / 1ps

// Multichannel one-pole smoother with separate attack and release weights:
// y' = x*(1-a) + y*a in signed Q16.16, a in Q1.15 (coef_down when x < y,
// coef_up otherwise, values above 1.0 clamp to 1.0), rounded toward minus
// infinity. Op 0 filters channel 0 with its previously stored input and then
// stores the new one; op 1 stores the element's input and filters that
// channel; op 2 refilters channels 0 to count-1. Each result passes through
// the memory read, compare, multiply, sum and output register states after
// the item is accepted, and a replay of n channels gives its results one at
// a time through the single shared 33x17 multiplier and the registered read
// of the two channel memories. No item is taken until the last result of
// the previous one has been transferred. Both stores read as zero until
// written, so no clearing pass follows reset. Registers are to be written
// through the cfg port while the block is idle; the block itself does not
// enforce this, and cfg_ready is always high.

`include "asymmetric_one_pole_smoother_unit_defines.svh"

module asymmetric_one_pole_smoother_unit
  import aps_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic [CH_W-1:0]             in_channel,
  input  logic signed [DATA_W-1:0]    in_sample_in,
  input  logic                        in_list_end,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [CH_W-1:0]             out_channel,
  output logic signed [DATA_W-1:0]    out_smoothed,
  output logic                        out_last_of_run,

  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COEF_W-1:0]           cfg_data
);

  state_t state_r, state_nxt;

  op_t                      op_r;
  logic [CH_W-1:0]          ch_r;
  logic [CH_W-1:0]          last_ch_r;
  logic signed [DATA_W-1:0] sample_r;
  logic [CNT_W-1:0]         count_r;
  logic [COEF_W-1:0]        coef_up_r;
  logic [COEF_W-1:0]        coef_down_r;
  logic [CHANNELS-1:0]      in_vld_r;
  logic [CHANNELS-1:0]      out_vld_r;
  logic                     out_valid_r;

  logic signed [DATA_W-1:0] x_r;
  logic signed [DATA_W:0]   diff_r;
  logic [COEF_W-1:0]        coef_r;
  logic signed [49:0]       prod_r;
  logic [CH_W-1:0]          out_channel_r;
  logic signed [DATA_W-1:0] out_smoothed_r;
  logic                     out_last_r;

  logic                     in_xfer;
  logic                     out_xfer;
  logic                     list_ok;
  logic [CNT_W-1:0]         cnt_clip;
  logic                     in_we;
  logic                     out_we;
  logic [DATA_W-1:0]        in_rdata;
  logic [DATA_W-1:0]        out_rdata;
  logic signed [DATA_W-1:0] x_sel;
  logic signed [DATA_W-1:0] y_sel;
  logic signed [DATA_W:0]   diff_nxt;
  logic [COEF_W-1:0]        coef_nxt;
  logic signed [49:0]       prod_nxt;
  logic signed [DATA_W-1:0] smoothed_nxt;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid_r && out_ready;
  assign list_ok  = {1'b0, in_channel} < CNT_W'(CHANNELS);
  assign cnt_clip = (count_r > CNT_W'(CHANNELS)) ? CNT_W'(CHANNELS) : count_r;

  // channel stores
  aps_ram #(.WIDTH(DATA_W), .DEPTH(CHANNELS)) u_in_store (
    .clk   (clk),
    .we    (in_we),
    .waddr (ch_r),
    .wdata (sample_r),
    .raddr (ch_r),
    .rdata (in_rdata)
  );

  aps_ram #(.WIDTH(DATA_W), .DEPTH(CHANNELS)) u_out_store (
    .clk   (clk),
    .we    (out_we),
    .waddr (ch_r),
    .wdata (smoothed_nxt),
    .raddr (ch_r),
    .rdata (out_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_op))
            OP_SINGLE: state_nxt = ST_READ;
            OP_LIST:   state_nxt = list_ok ? ST_READ : ST_IDLE;
            OP_REPLAY: state_nxt = (cnt_clip != '0) ? ST_READ : ST_IDLE;
            OP_NOP:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = out_last_r ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_we    = (state_r == ST_SUM);
    in_we     = (state_r == ST_SUM) && (op_r != OP_REPLAY);
    cfg_ready = 1'b1;
  end

  // datapath: compare, multiply, sum through the one multiplier
  always_comb begin
    x_sel = (op_r == OP_LIST) ? sample_r :
            (in_vld_r[ch_r] ? $signed(in_rdata) : '0);
    y_sel = out_vld_r[ch_r] ? $signed(out_rdata) : '0;
    // y' = x + floor((y - x) * a / 2^15)
    diff_nxt     = {y_sel[DATA_W-1], y_sel} - {x_sel[DATA_W-1], x_sel};
    coef_nxt     = (x_sel < y_sel) ? sat_coef(coef_down_r) : sat_coef(coef_up_r);
    prod_nxt     = diff_r * $signed({1'b0, coef_r});
    smoothed_nxt = x_r + $signed(prod_r[46:15]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_NOP;
      ch_r        <= '0;
      last_ch_r   <= '0;
      count_r     <= '0;
      coef_up_r   <= COEF_UP_RST;
      coef_down_r <= COEF_DOWN_RST;
      in_vld_r    <= '0;
      out_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_COEF_UP) begin
          coef_up_r <= cfg_data;
        end else if (cfg_index == CFG_COEF_DOWN) begin
          coef_down_r <= cfg_data;
        end
      end

      if (in_xfer) begin
        op_r <= op_t'(in_op);
        unique case (op_t'(in_op))
          OP_SINGLE: begin
            ch_r      <= '0;
            last_ch_r <= '0;
            count_r   <= CNT_W'(1);
          end
          OP_LIST: begin
            ch_r      <= in_channel;
            last_ch_r <= in_channel;
            if (list_ok && in_list_end) begin
              count_r <= {1'b0, in_channel} + CNT_W'(1);
            end
          end
          OP_REPLAY: begin
            ch_r      <= '0;
            last_ch_r <= CH_W'(cnt_clip - CNT_W'(1));
          end
          OP_NOP: ;
        endcase
      end

      if (state_r == ST_SUM) begin
        out_vld_r[ch_r] <= 1'b1;
        if (op_r != OP_REPLAY) begin
          in_vld_r[ch_r] <= 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
        if (!out_last_r) begin
          ch_r <= ch_r + CH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r <= in_sample_in;
    end
    if (state_r == ST_PREP) begin
      x_r    <= x_sel;
      diff_r <= diff_nxt;
      coef_r <= coef_nxt;
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_nxt;
    end
    if (state_r == ST_SUM) begin
      out_channel_r  <= ch_r;
      out_smoothed_r <= smoothed_nxt;
      out_last_r     <= (op_r != OP_REPLAY) || (ch_r == last_ch_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = out_channel_r;
  assign out_smoothed    = out_smoothed_r;
  assign out_last_of_run = out_last_r;

  `APS_ASSERT_NOW(a_out_only_in_out_state, out_valid_r, state_r == ST_OUT,
    "result shown outside the output state")
  `APS_ASSERT_NEXT(a_empty_replay_stays_idle,
    in_xfer && (op_t'(in_op) == OP_REPLAY) && (count_r == '0), state_r == ST_IDLE,
    "replay with empty count left idle")
  `APS_ASSERT_NOW(a_replay_in_range,
    (state_r != ST_IDLE) && (op_r == OP_REPLAY), ch_r <= last_ch_r,
    "replay channel ran past the count")
  `APS_ASSERT_NEXT(a_last_returns_idle, out_xfer && out_last_r, state_r == ST_IDLE,
    "final transfer did not return to idle")

endmodule

>>> rtl/aps_ram.sv
`timescale 1ns / 1ps

module aps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/asymmetric_one_pole_smoother_unit_tb.sv
`timescale 1ns / 1ps

module asymmetric_one_pole_smoother_unit_tb;
  import aps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int SETTLE = 12;

  typedef struct packed {
    op_t               op;
    logic [CH_W-1:0]   ch;
    logic [DATA_W-1:0] value;
    logic              fin;
  } pend_item_t;

  typedef struct packed {
    logic [CH_W-1:0]          ch;
    logic signed [DATA_W-1:0] value;
    logic                     fin;
  } smooth_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_op = OP_NOP;
  logic [CH_W-1:0]          in_channel = '0;
  logic signed [DATA_W-1:0] in_sample_in = '0;
  logic                     in_list_end = 1'b0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [CH_W-1:0]          out_channel;
  logic signed [DATA_W-1:0] out_smoothed;
  logic                     out_last_of_run;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_COEF_UP;
  logic [COEF_W-1:0]    cfg_data = '0;

  // own copy of the block state
  logic [COEF_W-1:0]        model_up = COEF_UP_RST;
  logic [COEF_W-1:0]        model_down = COEF_DOWN_RST;
  logic signed [DATA_W-1:0] held_in [CHANNELS];
  logic signed [DATA_W-1:0] held_out [CHANNELS];
  int unsigned              active_n = 0;

  pend_item_t     pending_items [$];
  smooth_result_t smooth_expect [$];
  pend_item_t     next_item;
  smooth_result_t want;

  bit          no_gaps = 1'b0;
  int unsigned item_total = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  asymmetric_one_pole_smoother_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_channel     (in_channel),
    .in_sample_in   (in_sample_in),
    .in_list_end    (in_list_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .out_smoothed   (out_smoothed),
    .out_last_of_run(out_last_of_run),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  // y' = x*(1-a) + y*a, floored, stored back as the channel output
  function automatic logic signed [DATA_W-1:0] blend_channel(input int unsigned ch);
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic [COEF_W-1:0]        w;
    longint                   acc;
    x = held_in[ch];
    y = held_out[ch];
    w = (x < y) ? model_down : model_up;
    if (w > COEF_ONE) w = COEF_ONE;
    acc = longint'(x) * (longint'(COEF_ONE) - longint'(w)) + longint'(y) * longint'(w);
    acc = acc >>> 15;
    held_out[ch] = acc[DATA_W-1:0];
    return acc[DATA_W-1:0];
  endfunction

  function automatic void predict_item(input op_t op, input logic [CH_W-1:0] ch,
                                       input logic signed [DATA_W-1:0] value,
                                       input logic fin);
    int unsigned n;
    logic signed [DATA_W-1:0] y;
    case (op)
      OP_SINGLE: begin
        y = blend_channel(0);
        held_in[0] = value;
        active_n = 1;
        smooth_expect.push_back('{ch: '0, value: y, fin: 1'b1});
      end
      OP_LIST: begin
        if (ch < CHANNELS) begin
          held_in[ch] = value;
          y = blend_channel(ch);
          if (fin) active_n = ch + 1;
          smooth_expect.push_back('{ch: ch, value: y, fin: 1'b1});
        end
      end
      OP_REPLAY: begin
        n = (active_n > CHANNELS) ? CHANNELS : active_n;
        for (int i = 0; i < n; i++) begin
          y = blend_channel(i);
          smooth_expect.push_back('{ch: CH_W'(i), value: y, fin: (i == n - 1)});
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_item(input op_t op, input int unsigned ch,
                                     input logic [DATA_W-1:0] value, input bit fin);
    pend_item_t it;
    it.op = op;
    it.ch = CH_W'(ch);
    it.value = value;
    it.fin = fin;
    pending_items.push_back(it);
    if (op != OP_NOP) item_total++;
  endfunction

  function automatic logic [DATA_W-1:0] rand_sample();
    int unsigned pick;
    logic [DATA_W-1:0] r;
    pick = $urandom_range(7);
    r = $urandom;
    if (pick < 4) return r;
    if (pick < 6) return {{12{r[19]}}, r[19:0]};
    case ($urandom_range(3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick < 14) return COEF_W'($urandom_range(32768));
    if (pick < 17) return pick[0] ? COEF_ONE : '0;
    return COEF_W'($urandom_range(65535, 32769));
  endfunction

  function automatic void queue_replay();
    queue_item(OP_REPLAY, $urandom_range(63), rand_sample(), 1'($urandom_range(1)));
  endfunction

  // mostly full lists followed by replays, the rest loose traffic
  function automatic void random_burst();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(99);
    if (kind < 55) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
      for (int c = 0; c < n; c++) queue_item(OP_LIST, c, rand_sample(), c == n - 1);
      repeat ($urandom_range(3, 1)) queue_replay();
    end else if (kind < 70) begin
      repeat ($urandom_range(4, 1))
        queue_item(OP_SINGLE, $urandom_range(63), rand_sample(), 1'($urandom_range(1)));
      if ($urandom_range(1)) queue_replay();
    end else if (kind < 85) begin
      queue_item(OP_LIST, $urandom_range(63), rand_sample(), 1'($urandom_range(1)));
    end else if (kind < 95) begin
      queue_replay();
    end else begin
      queue_item(OP_NOP, $urandom_range(63), rand_sample(), 1'($urandom_range(1)));
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // hold off until the queue is empty and every result is back
  task automatic drain();
    do @(negedge clk); while (pending_items.size() != 0 || in_valid || smooth_expect.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatch_count < 10) $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && (no_gaps || $urandom_range(99) >= 18)) begin
        next_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_op <= next_item.op;
        in_channel <= next_item.ch;
        in_sample_in <= next_item.value;
        in_list_end <= next_item.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= no_gaps || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COEF_UP:   model_up = cfg_data;
        CFG_COEF_DOWN: model_down = cfg_data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        predict_item(op_t'(in_op), in_channel, in_sample_in, in_list_end);
      if (out_valid && out_ready) begin
        if (smooth_expect.size() == 0) begin
          flag_mismatch($sformatf("unexpected result ch %0d value %h last %b",
                                  out_channel, out_smoothed, out_last_of_run));
        end else begin
          want = smooth_expect.pop_front();
          if (want.ch !== out_channel || want.value !== out_smoothed ||
              want.fin !== out_last_of_run)
            flag_mismatch($sformatf("expected ch %0d value %h last %b, got ch %0d value %h last %b",
                                    want.ch, want.value, want.fin,
                                    out_channel, out_smoothed, out_last_of_run));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("asymmetric_one_pole_smoother_unit test failed");
      $finish;
    end
  end

  initial begin
    int unsigned goal;
    foreach (held_in[i]) begin
      held_in[i] = '0;
      held_out[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset weights: empty replay, unused op, value extremes, full channel range
    queue_item(OP_REPLAY, 0, '0, 1'b0);
    queue_item(OP_NOP, 63, '1, 1'b1);
    queue_item(OP_SINGLE, 0, 32'h7FFF_FFFF, 1'b0);
    queue_item(OP_SINGLE, 0, 32'h8000_0000, 1'b0);
    queue_item(OP_SINGLE, 0, '0, 1'b0);
    queue_item(OP_LIST, 63, '1, 1'b1);
    queue_item(OP_REPLAY, 0, '0, 1'b0);
    queue_item(OP_LIST, 0, 32'h7FFF_FFFF, 1'b0);
    queue_item(OP_LIST, 5, 32'h8000_0000, 1'b1);
    queue_item(OP_REPLAY, 0, '0, 1'b0);
    queue_item(OP_SINGLE, 0, 32'h1234_5678, 1'b0);
    queue_item(OP_REPLAY, 0, '0, 1'b0);
    drain();

    // weight extremes, then weights above one that clamp
    write_reg(CFG_COEF_UP, '0);
    write_reg(CFG_COEF_DOWN, COEF_ONE);
    queue_item(OP_SINGLE, 0, 32'h7FFF_FFFF, 1'b0);
    queue_item(OP_SINGLE, 0, 32'h8000_0000, 1'b0);
    queue_item(OP_LIST, 3, 32'hFFFF_0000, 1'b1);
    queue_item(OP_REPLAY, 0, '0, 1'b0);
    drain();
    write_reg(CFG_COEF_UP, '1);
    write_reg(CFG_COEF_DOWN, COEF_ONE + 16'd1);
    queue_item(OP_SINGLE, 0, 32'h8000_0000, 1'b0);
    queue_item(OP_LIST, 2, 32'h7FFF_FFFF, 1'b0);
    queue_item(OP_REPLAY, 0, '0, 1'b0);
    drain();
    write_reg(CFG_COEF_UP, COEF_ONE);
    write_reg(CFG_COEF_DOWN, '0);
    queue_item(OP_LIST, 1, 32'h0001_8000, 1'b0);
    queue_item(OP_SINGLE, 0, 32'hFFFF_8000, 1'b0);
    queue_item(OP_REPLAY, 0, '0, 1'b0);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      write_reg(CFG_COEF_UP, rand_coef());
      write_reg(CFG_COEF_DOWN, rand_coef());
      no_gaps = (phase == 2);
      goal = item_total + 28;
      while (item_total < goal) random_burst();
    end
    drain();

    if (mismatch_count == 0 && smooth_expect.size() == 0) begin
      $display("asymmetric_one_pole_smoother_unit test passed");
    end else begin
      $display("asymmetric_one_pole_smoother_unit test failed");
    end
    $finish;
  end

endmodule
